// ===== hw/rtl/aldd_pkg.sv =====
package aldd_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int DETECT_W    = 8;
    localparam int THRESH_W    = 12;
    localparam int CODE_W      = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 1;

    localparam int LEVEL_SHIFT_DEF = 8;

    localparam logic [DETECT_W-1:0] DETECT_RST = DETECT_W'(10);
    localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(128);

    localparam logic [CODE_W-1:0] CODE_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DETECT_COUNT    = 1'b0,
        REG_PRESS_THRESHOLD = 1'b1
    } t_reg_idx;

endpackage

// ===== hw/rtl/adc_ladder_key_debounce_decoder_core.sv =====
// Resistor-ladder keypad front end: takes one 12-bit ADC sample per request, debounces the
// pressed/released decision (sample above press_threshold) over detect_count consecutive
// opposite samples, and on each flip rounds the sample to a ladder level of 2^LEVEL_SHIFT
// to form no_key and key_code. Every sample gives one result with a changed flag. The block
// takes one sample per cycle while the result side is not stalled; a sample's result reaches
// the outputs through an input register and a result register around one pass of
// compare/round logic. A stalled result holds the input register, and a new sample is taken
// in the same cycle that a waiting result leaves. Write configuration only while no sample
// is in flight.
module adc_ladder_key_debounce_decoder_core #(
    parameter int LEVEL_SHIFT = aldd_pkg::LEVEL_SHIFT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aldd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [aldd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [aldd_pkg::SAMPLE_W-1:0]       i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_changed,
    output logic                                o_no_key,
    output logic [aldd_pkg::CODE_W-1:0]         o_key_code
);
    import aldd_pkg::*;

    localparam int SumW   = SAMPLE_W + 1;
    localparam int LevelW = SumW - LEVEL_SHIFT;
    localparam logic [SumW-1:0] Half = SumW'(1) << (LEVEL_SHIFT - 1);
    localparam logic [SumW-1:0] LevelSat = SumW'(CODE_MAX) + SumW'(1);

    logic [DETECT_W-1:0] r_detect;
    logic [THRESH_W-1:0] r_thresh;

    logic                r_s1_valid;
    logic [SAMPLE_W-1:0] r_sample;

    logic                r_pressed;
    logic [DETECT_W-1:0] r_count;
    logic                r_no_key;
    logic [CODE_W-1:0]   r_code;

    logic                r_out_valid;
    logic                r_changed;
    logic                r_out_no_key;
    logic [CODE_W-1:0]   r_out_code;

    logic                s2_ready;
    logic                s1_ready;
    logic                s1_fire;
    logic                pressed;
    logic [DETECT_W-1:0] count_inc;
    logic                flip;
    logic [SumW-1:0]     sum;
    logic [LevelW-1:0]   level;
    logic [SumW-1:0]     level_ext;
    logic                n_pressed;
    logic [DETECT_W-1:0] n_count;
    logic                n_no_key;
    logic [CODE_W-1:0]   n_code;

    assign s2_ready   = !r_out_valid || !i_out_stall;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign s1_fire    = r_s1_valid && s2_ready;
    assign o_in_stall = !s1_ready;

    assign pressed   = r_sample > r_thresh;
    assign count_inc = r_count + DETECT_W'(1);
    assign flip      = (pressed != r_pressed) && (count_inc >= r_detect);

    assign sum       = {1'b0, r_sample} + Half;
    assign level     = sum[SumW-1:LEVEL_SHIFT];
    assign level_ext = SumW'(level);

    always_comb begin
        n_pressed = r_pressed;
        n_count   = r_count;
        n_no_key  = r_no_key;
        n_code    = r_code;
        if (pressed == r_pressed) begin
            n_count = '0;
        end else if (flip) begin
            n_count   = '0;
            n_pressed = pressed;
            if (level_ext == '0) begin
                n_no_key = 1'b1;
            end else begin
                n_no_key = 1'b0;
                if (level_ext > LevelSat) begin
                    n_code = CODE_MAX;
                end else begin
                    n_code = CODE_W'(level_ext - SumW'(1));
                end
            end
        end else begin
            n_count = count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect <= DETECT_RST;
            r_thresh <= THRESH_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DETECT_COUNT:    r_detect <= i_cfg_wdata[DETECT_W-1:0];
                REG_PRESS_THRESHOLD: r_thresh <= i_cfg_wdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pressed   <= 1'b0;
            r_count     <= '0;
            r_no_key    <= 1'b1;
            r_code      <= '0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                r_pressed <= n_pressed;
                r_count   <= n_count;
                r_no_key  <= n_no_key;
                r_code    <= n_code;
            end
        end
    end

    // hold payloads while stalled
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_sample <= i_sample;
        end
        if (s1_fire) begin
            r_changed    <= flip;
            r_out_no_key <= n_no_key;
            r_out_code   <= n_code;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_changed   = r_changed;
    assign o_no_key    = r_out_no_key;
    assign o_key_code  = r_out_code;

`ifndef NO_ASSERTIONS
    a_state_holds_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_fire |=> $stable(r_pressed) && $stable(r_count) && $stable(r_no_key)
            && $stable(r_code))
        else $error("debounce state moved without a request");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire |=> o_out_valid && o_no_key == r_no_key && o_key_code == r_code)
        else $error("result does not match held key state");

    a_flip_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && flip |=> r_count == '0 && r_pressed != $past(r_pressed))
        else $error("flip did not toggle state and clear count");

    a_stalled_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_changed)
            && $stable(r_out_no_key) && $stable(r_out_code))
        else $error("stalled result lost or changed");
`endif

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aldd_pkg::*;

    localparam int LEVEL_SHIFT = LEVEL_SHIFT_DEF;
    localparam int MAX_GAP     = 11;
    localparam int SETTLE      = 4;

    typedef struct packed {
        logic              changed;
        logic              no_key;
        logic [CODE_W-1:0] key_code;
    } t_key_status;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [SAMPLE_W-1:0]   i_sample;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_changed;
    logic                  o_no_key;
    logic [CODE_W-1:0]     o_key_code;

    adc_ladder_key_debounce_decoder_core #(
        .LEVEL_SHIFT(LEVEL_SHIFT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_changed   (o_changed),
        .o_no_key    (o_no_key),
        .o_key_code  (o_key_code)
    );

    logic [DETECT_W-1:0] detect_q;
    logic [THRESH_W-1:0] thresh_q;
    logic                pressed_q;
    logic [DETECT_W-1:0] run_q;
    logic                no_key_q;
    logic [CODE_W-1:0]   code_q;

    t_key_status pending_status[$];
    t_key_status want;
    bit          no_idle;
    int          errors;
    int          samples_sent;
    int          flips_seen;
    int          results_checked;

    always #1 i_clk = ~i_clk;

    function automatic t_key_status debounce_decode(input logic [SAMPLE_W-1:0] s);
        t_key_status r;
        logic        pressed;
        int          level;
        pressed   = s > thresh_q;
        r.changed = 1'b0;
        if (pressed == pressed_q) begin
            run_q = '0;
        end else begin
            run_q = run_q + 8'd1;
            if (run_q >= detect_q) begin
                run_q     = '0;
                pressed_q = pressed;
                r.changed = 1'b1;
                level = (int'(s) + (1 << (LEVEL_SHIFT - 1))) >> LEVEL_SHIFT;
                if (level == 0) begin
                    no_key_q = 1'b1;
                end else begin
                    no_key_q = 1'b0;
                    code_q   = (level - 1 > int'(CODE_MAX)) ? CODE_MAX : CODE_W'(level - 1);
                end
            end
        end
        r.no_key   = no_key_q;
        r.key_code = code_q;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic pressed);
        int pick;
        pick = $urandom_range(0, 15);
        if (pressed && thresh_q != '1) begin
            if (pick == 0) return thresh_q + 1'b1;
            if (pick == 1) return '1;
            return SAMPLE_W'($urandom_range(int'(thresh_q) + 1, 4095));
        end
        if (!pressed) begin
            if (pick == 0) return thresh_q;
            if (pick == 1) return '0;
            return SAMPLE_W'($urandom_range(0, int'(thresh_q)));
        end
        return SAMPLE_W'($urandom_range(0, 4095));
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        errors++;
        if (errors <= 50)
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, exp_val);
    endtask

    // check each result against the oldest pending status
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_status.size() == 0) begin
                report_mismatch("unexpected result, changed", o_changed, 0);
            end else begin
                want = pending_status.pop_front();
                results_checked++;
                if (o_changed !== want.changed)
                    report_mismatch("changed", o_changed, want.changed);
                if (o_no_key !== want.no_key)
                    report_mismatch("no_key", o_no_key, want.no_key);
                if (o_key_code !== want.key_code)
                    report_mismatch("key_code", o_key_code, want.key_code);
            end
        end
    end

    // result-side stall: randomly hold off each result unless no_idle is set
    initial begin
        int n;
        forever begin
            n = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        t_key_status r;
        int          gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        r = debounce_decode(s);
        pending_status.push_back(r);
        samples_sent++;
        if (r.changed) flips_seen++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] detect_data,
                              input logic [CFG_DATA_W-1:0] thresh_data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_DETECT_COUNT;
        i_cfg_wdata <= detect_data;
        @(posedge i_clk);
        detect_q     = detect_data[DETECT_W-1:0];
        i_cfg_idx   <= REG_PRESS_THRESHOLD;
        i_cfg_wdata <= thresh_data;
        @(posedge i_clk);
        thresh_q  = thresh_data[THRESH_W-1:0];
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_sample(12'd0);
        send_sample(12'd128);
        repeat (8) send_sample(12'd129);
        send_sample(12'd128);
        repeat (9) send_sample(12'd129);
        send_sample(12'hfff);
    endtask

    task automatic test_detect_zero();
        drain_results();
        set_config(12'hf00, 12'd128);
        send_sample(12'd200);
        send_sample(12'd128);
        send_sample(12'd0);
        send_sample(12'd384);
        send_sample(12'd0);
    endtask

    task automatic test_threshold_extremes();
        drain_results();
        set_config(12'h001, 12'd0);
        send_sample(12'd1);
        send_sample(12'd0);
        drain_results();
        set_config(12'h0ff, 12'hfff);
        send_sample(12'hfff);
        drain_results();
        set_config(12'hfff, 12'd0);
        send_sample(12'hfff);
        send_sample(12'd0);
    endtask

    task automatic run_phase(input logic [DETECT_W-1:0] detect,
                             input logic [THRESH_W-1:0] thresh, input int n_items);
        int   sent;
        int   len;
        logic side;
        drain_results();
        set_config({4'($urandom_range(0, 15)), detect}, thresh);
        sent = 0;
        while (sent < n_items) begin
            no_idle = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) != 0) begin
                side = ($urandom_range(0, 7) == 0) ? pressed_q : !pressed_q;
                len  = int'(detect) + $urandom_range(0, 3);
            end else begin
                side = 1'($urandom_range(0, 1));
                len  = $urandom_range(1, detect > 1 ? int'(detect) - 1 : 1);
            end
            if (len < 1) len = 1;
            repeat (len) send_sample(pick_sample(side));
            sent += len;
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_debounce();
        run_phase(8'd3, 12'd128, 120);
        run_phase(8'd1, 12'($urandom_range(0, 4095)), 80);
        run_phase(8'd0, 12'($urandom_range(0, 4095)), 60);
        run_phase(8'd255, 12'($urandom_range(1000, 3000)), 420);
        run_phase(8'($urandom_range(2, 20)), 12'($urandom_range(0, 4095)), 150);
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_DETECT_COUNT;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        no_idle     = 1'b0;
        detect_q    = DETECT_RST;
        thresh_q    = THRESH_RST;
        pressed_q   = 1'b0;
        run_q       = '0;
        no_key_q    = 1'b1;
        code_q      = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_detect_zero();
        test_threshold_extremes();
        test_random_debounce();
        drain_results();

        $display("run: %0d samples sent, %0d debounce flips, %0d results checked",
                 samples_sent, flips_seen, results_checked);
        $display("detect counts 0 to 255, thresholds 0 to 4095, %0d mismatches", errors);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d results pending", pending_status.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/aldd_pkg.sv
hw/rtl/adc_ladder_key_debounce_decoder_core.sv
dv/tb.sv
